@@ design/dtc_pkg.sv @@
// shared constants, types and helper functions for the decimal time clock counter
package dtc_pkg;

  // scan step divider
  localparam int SCAN_DIVIDE = 16;
  localparam int SCAN_W      = (SCAN_DIVIDE > 2) ? $clog2(SCAN_DIVIDE) : 1;

  // register widths
  localparam int INC_W   = 16;
  localparam int MOD_W   = 17;
  localparam int THR_W   = 8;
  localparam int CFG_W   = MOD_W;
  localparam int CFG_IDX_W = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_STEP_INCREMENT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_MODULUS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_THRESHOLD = 2'd2;

  // register reset values
  localparam logic [INC_W-1:0] INC_RESET = 16'd256;
  localparam logic [MOD_W-1:0] MOD_RESET = 17'd86400;
  localparam logic [THR_W-1:0] THR_RESET = 8'd10;

  // display constants
  localparam logic [7:0] DP_BIT   = 8'h40;
  localparam logic [7:0] SEG_ZERO = 8'h50;
  localparam logic [3:0] DIGIT_MAX = 4'd9;

  // stream widths
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 40;

  // one two-digit decimal counter
  typedef struct packed {
    logic [3:0] tens;
    logic [3:0] units;
  } pair_t;

  // active-low segment pattern of one digit, bit 6 is the decimal point
  function automatic logic [7:0] seg_of(input logic [3:0] d);
    logic [7:0] s;
    case (d)
      4'd0:    s = 8'h50;
      4'd1:    s = 8'hD7;
      4'd2:    s = 8'h64;
      4'd3:    s = 8'h45;
      4'd4:    s = 8'hC3;
      4'd5:    s = 8'h49;
      4'd6:    s = 8'h48;
      4'd7:    s = 8'hD5;
      4'd8:    s = 8'h40;
      4'd9:    s = 8'h41;
      default: s = SEG_ZERO;
    endcase
    return s;
  endfunction

  // advance a pair by one, wrapping 99 to 0
  function automatic pair_t pair_bump(input pair_t p);
    pair_t r;
    r = p;
    if (p.units >= DIGIT_MAX) begin
      r.units = 4'd0;
      if (p.tens >= DIGIT_MAX) begin
        r.tens = 4'd0;
      end else begin
        r.tens = p.tens + 4'd1;
      end
    end else begin
      r.units = p.units + 4'd1;
    end
    return r;
  endfunction

  // true when a bump of this pair wraps to 0
  function automatic logic pair_wraps(input pair_t p);
    return (p.units >= DIGIT_MAX) && (p.tens >= DIGIT_MAX);
  endfunction

endpackage

@@ design/decimal_time_clock_counter_top.sv @@
// decimal time clock counter with multiplexed four-digit display, top level
//
// channel   dir  handshake            payload
// s_*       in   s_tvalid/s_tready    s_tdata: button_centival, button_interval
// m_*       out  m_tvalid/m_tready    m_tuser: scan_strobe; m_tdata: display and digits
// cfg_*     in   cfg_we               cfg_index, cfg_data (17 bit)
//
// one item per clock while s_tready is high: the phase adder, the tick cascade and
// the button timers are short logic between the state registers and the result register
// a result register with a one-entry skid stage lets an item in while a result waits
// s_tready drops only when the skid stage is full
// rst is synchronous and active high; it clears state and both output stages
module decimal_time_clock_counter_top (
  input  logic                            clk,
  input  logic                            rst,
  // item in
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [dtc_pkg::IN_DATA_W-1:0]   s_tdata,   // [0] button_centival, [1] button_interval
  // item out
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [dtc_pkg::OUT_DATA_W-1:0]  m_tdata,   // [3:0] digit_enable, [11:4] segment_drive,
                                                     // [15:12] interval_tens, [19:16] interval_units,
                                                     // [23:20] centival_tens, [27:24] centival_units,
                                                     // [31:28] tick_tens, [35:32] tick_units
  output logic                            m_tuser,   // [0] scan_strobe
  // configuration writes
  input  logic                            cfg_we,
  input  logic [dtc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dtc_pkg::CFG_W-1:0]       cfg_data
);

  localparam logic [dtc_pkg::SCAN_W-1:0] SCAN_LAST = dtc_pkg::SCAN_W'(dtc_pkg::SCAN_DIVIDE - 1);

  // configuration registers
  logic [dtc_pkg::INC_W-1:0] step_increment;
  logic [dtc_pkg::MOD_W-1:0] step_modulus;
  logic [dtc_pkg::THR_W-1:0] press_threshold;

  // clock state
  logic [dtc_pkg::MOD_W-1:0]  acc;
  logic                       tick_pending;
  logic [dtc_pkg::SCAN_W-1:0] scan_div;
  dtc_pkg::pair_t             ticks, cents, intvs;
  logic [3:0][7:0]            disp;
  logic [1:0]                 ptr;
  logic [3:0]                 en_latch;
  logic [7:0]                 seg_latch;
  logic [7:0]                 dur_cent, dur_intv;

  // next values
  logic [dtc_pkg::MOD_W-1:0]  acc_next;
  logic                       tick_pending_next;
  logic [dtc_pkg::SCAN_W-1:0] scan_div_next;
  dtc_pkg::pair_t             ticks_next, cents_next, intvs_next;
  logic [3:0][7:0]            disp_next;
  logic [1:0]                 ptr_next;
  logic [3:0]                 en_latch_next;
  logic [7:0]                 seg_latch_next;
  logic [7:0]                 dur_cent_next, dur_intv_next;
  logic                       scan;

  // phase adder
  logic [dtc_pkg::MOD_W:0] acc_sum, acc_diff;
  logic                    tick_set;

  // output stages
  logic                            skid_valid;
  logic [dtc_pkg::OUT_DATA_W-1:0]  skid_data;
  logic                            skid_user;
  logic [dtc_pkg::OUT_DATA_W-1:0]  res_data;
  logic                            in_acc, out_pop;

  assign s_tready = !skid_valid;
  assign in_acc   = s_tvalid && s_tready;
  assign out_pop  = m_tvalid && m_tready;

  // configuration port, indexes beyond the list are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      step_increment  <= dtc_pkg::INC_RESET;
      step_modulus    <= dtc_pkg::MOD_RESET;
      press_threshold <= dtc_pkg::THR_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        dtc_pkg::REG_STEP_INCREMENT:  step_increment  <= cfg_data[dtc_pkg::INC_W-1:0];
        dtc_pkg::REG_STEP_MODULUS:    step_modulus    <= cfg_data;
        dtc_pkg::REG_PRESS_THRESHOLD: press_threshold <= cfg_data[dtc_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  // phase accumulator: one subtract of the modulus, then saturate to 17 bits
  always_comb begin
    acc_sum  = {1'b0, acc} + {2'b00, step_increment};
    tick_set = (acc_sum >= {1'b0, step_modulus});
    acc_diff = tick_set ? (acc_sum - {1'b0, step_modulus}) : acc_sum;
    acc_next = acc_diff[dtc_pkg::MOD_W] ? '1 : acc_diff[dtc_pkg::MOD_W-1:0];
  end

  // scan step: tick cascade, digit scan, then button timers in that order
  always_comb begin
    scan              = (scan_div == SCAN_LAST);
    scan_div_next     = scan ? '0 : scan_div + dtc_pkg::SCAN_W'(1);
    tick_pending_next = tick_pending | tick_set;
    ticks_next        = ticks;
    cents_next        = cents;
    intvs_next        = intvs;
    disp_next         = disp;
    ptr_next          = ptr;
    en_latch_next     = en_latch;
    seg_latch_next    = seg_latch;
    dur_cent_next     = dur_cent;
    dur_intv_next     = dur_intv;

    if (scan) begin
      tick_pending_next = 1'b0;
      if (tick_pending | tick_set) begin
        ticks_next = dtc_pkg::pair_bump(ticks);
        // decimal point flips on every wrap of the tick units
        if (ticks.units >= dtc_pkg::DIGIT_MAX) begin
          disp_next[1] = disp[1] ^ dtc_pkg::DP_BIT;
        end
        if (dtc_pkg::pair_wraps(ticks)) begin
          cents_next   = dtc_pkg::pair_bump(cents);
          disp_next[3] = dtc_pkg::seg_of(cents_next.units);
          disp_next[2] = dtc_pkg::seg_of(cents_next.tens);
          if (dtc_pkg::pair_wraps(cents)) begin
            intvs_next   = dtc_pkg::pair_bump(intvs);
            disp_next[1] = dtc_pkg::seg_of(intvs_next.units);
            disp_next[0] = dtc_pkg::seg_of(intvs_next.tens);
          end
        end
      end

      // drive the next digit with the byte as it stands after the cascade
      ptr_next       = ptr + 2'd1;
      en_latch_next  = 4'b0001 << ptr_next;
      seg_latch_next = disp_next[ptr_next];

      // centival button: advance on release of a long press, no carry
      if (s_tdata[0]) begin
        if (dur_cent != 8'hFF) begin
          dur_cent_next = dur_cent + 8'd1;
        end
      end else begin
        if (dur_cent > press_threshold) begin
          cents_next   = dtc_pkg::pair_bump(cents_next);
          disp_next[3] = dtc_pkg::seg_of(cents_next.units);
          disp_next[2] = dtc_pkg::seg_of(cents_next.tens);
        end
        dur_cent_next = 8'd0;
      end

      // interval button, same scheme
      if (s_tdata[1]) begin
        if (dur_intv != 8'hFF) begin
          dur_intv_next = dur_intv + 8'd1;
        end
      end else begin
        if (dur_intv > press_threshold) begin
          intvs_next   = dtc_pkg::pair_bump(intvs_next);
          disp_next[1] = dtc_pkg::seg_of(intvs_next.units);
          disp_next[0] = dtc_pkg::seg_of(intvs_next.tens);
        end
        dur_intv_next = 8'd0;
      end
    end
  end

  // result item packed lowest field first
  assign res_data = {4'b0000, ticks_next.units, ticks_next.tens,
                     cents_next.units, cents_next.tens,
                     intvs_next.units, intvs_next.tens,
                     seg_latch_next, en_latch_next};

  // state advances on every accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      acc          <= '0;
      tick_pending <= 1'b0;
      scan_div     <= '0;
      ticks        <= '0;
      cents        <= '0;
      intvs        <= '0;
      disp         <= {4{dtc_pkg::SEG_ZERO}};
      ptr          <= 2'd0;
      en_latch     <= 4'd0;
      seg_latch    <= 8'd0;
      dur_cent     <= 8'd0;
      dur_intv     <= 8'd0;
    end else if (in_acc) begin
      acc          <= acc_next;
      tick_pending <= tick_pending_next;
      scan_div     <= scan_div_next;
      ticks        <= ticks_next;
      cents        <= cents_next;
      intvs        <= intvs_next;
      disp         <= disp_next;
      ptr          <= ptr_next;
      en_latch     <= en_latch_next;
      seg_latch    <= seg_latch_next;
      dur_cent     <= dur_cent_next;
      dur_intv     <= dur_intv_next;
    end
  end

  // result register plus skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_pop) begin
        m_tvalid   <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (in_acc) begin
      if (!m_tvalid || out_pop) begin
        m_tvalid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (out_pop) begin
      m_tvalid <= 1'b0;
    end
  end

  // payload side, no reset needed
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_pop) begin
        m_tdata <= skid_data;
        m_tuser <= skid_user;
      end
    end else if (in_acc) begin
      if (!m_tvalid || out_pop) begin
        m_tdata <= res_data;
        m_tuser <= scan;
      end else begin
        skid_data <= res_data;
        skid_user <= scan;
      end
    end
  end

`ifndef SYNTH
  // the skid stage only fills behind a waiting result
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> m_tvalid)
    else $error("skid stage full with empty result register");

  // a scan step always leaves exactly one digit line driven
  a_scan_drives_digit: assert property (@(posedge clk) disable iff (rst)
    (in_acc && scan) |=> $onehot(en_latch))
    else $error("digit line not one-hot after scan step");

  // counter digits stay decimal
  a_digits_decimal: assert property (@(posedge clk) disable iff (rst)
    ticks.units <= 4'd9 && ticks.tens <= 4'd9 && cents.units <= 4'd9 &&
    cents.tens <= 4'd9 && intvs.units <= 4'd9 && intvs.tens <= 4'd9)
    else $error("counter digit above nine");

  // pending tick is consumed by every scan step
  a_scan_clears_tick: assert property (@(posedge clk) disable iff (rst)
    (in_acc && scan) |=> !tick_pending)
    else $error("tick left pending after scan step");
`endif

endmodule

@@ tb/sv/decimal_time_clock_counter_checker.sv @@
// checker for the decimal time clock counter: predicts every result and compares it
module decimal_time_clock_counter_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  input  logic                           s_tready,
  input  logic [dtc_pkg::IN_DATA_W-1:0]  s_tdata,    // [0] button_centival, [1] button_interval
  input  logic                           m_tvalid,
  input  logic                           m_tready,
  input  logic [dtc_pkg::OUT_DATA_W-1:0] m_tdata,    // [3:0] digit_enable, [11:4] segment_drive,
                                                     // [15:12] interval_tens, [19:16] interval_units,
                                                     // [23:20] centival_tens, [27:24] centival_units,
                                                     // [31:28] tick_tens, [35:32] tick_units
  input  logic                           m_tuser,    // [0] scan_strobe
  input  logic                           cfg_we,
  input  logic [dtc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dtc_pkg::CFG_W-1:0]      cfg_data,
  output int                             errors,
  output int                             outstanding,
  output int                             checked,
  output int                             scans,
  output int                             advances
);
  timeunit 1ns;
  timeprecision 1ps;
  import dtc_pkg::*;

  typedef struct packed {
    logic       scan;
    logic [3:0] enable;
    logic [7:0] segments;
    pair_t      intervals;
    pair_t      centivals;
    pair_t      ticks;
  } reading_t;

  // active-low glyphs, digit 0 in the lowest byte
  localparam logic [79:0] GLYPHS = {8'h41, 8'h40, 8'hD5, 8'h48, 8'h49,
                                    8'hC3, 8'h45, 8'h64, 8'hD7, 8'h50};
  localparam int BTN_CENTIVAL = 0;
  localparam int BTN_INTERVAL = 1;
  localparam int MAX_PRINTS   = 40;

  logic [INC_W-1:0] incr;
  logic [MOD_W-1:0] modulus;
  logic [THR_W-1:0] threshold;

  logic [MOD_W-1:0] phase;
  logic             tick_owed;
  int               divider;
  pair_t            ticks, centivals, intervals;
  logic [7:0]       frame [4];
  logic [1:0]       cursor;
  logic [3:0]       enable_latch;
  logic [7:0]       segment_latch;
  logic [7:0]       held [2];
  reading_t         readings_due [$];

  function automatic logic [7:0] glyph(input logic [3:0] d);
    return GLYPHS[{d, 3'b000} +: 8];
  endfunction

  function automatic pair_t next_pair(input pair_t p);
    pair_t n;
    n = p;
    if (p.units == DIGIT_MAX) begin
      n.units = 4'd0;
      n.tens  = (p.tens == DIGIT_MAX) ? 4'd0 : p.tens + 4'd1;
    end else begin
      n.units = p.units + 4'd1;
    end
    return n;
  endfunction

  task automatic advance_intervals();
    intervals = next_pair(intervals);
    frame[1] = glyph(intervals.units);
    frame[0] = glyph(intervals.tens);
  endtask

  task automatic advance_centivals(output logic wrap);
    wrap = (centivals == 8'h99);
    centivals = next_pair(centivals);
    frame[3] = glyph(centivals.units);
    frame[2] = glyph(centivals.tens);
  endtask

  task automatic advance_ticks(output logic wrap);
    // each wrap of the units digit flips the decimal point
    if (ticks.units == DIGIT_MAX) frame[1] = frame[1] ^ DP_BIT;
    wrap = (ticks == 8'h99);
    ticks = next_pair(ticks);
  endtask

  task automatic time_button(input int which, input logic pressed);
    logic unused_wrap;
    if (pressed) begin
      if (held[which] != 8'hFF) held[which] = held[which] + 8'd1;
    end else begin
      if (held[which] > threshold) begin
        advances++;
        if (which == BTN_CENTIVAL) advance_centivals(unused_wrap);
        else advance_intervals();
      end
      held[which] = 8'd0;
    end
  endtask

  task automatic predict_reading(input logic [1:0] buttons);
    logic [MOD_W:0] sum;
    logic           wrap;
    reading_t       r;
    sum = phase + incr;
    if (sum >= modulus) begin
      sum = sum - modulus;
      tick_owed = 1'b1;
    end
    if (sum > {1'b0, {MOD_W{1'b1}}}) sum = {1'b0, {MOD_W{1'b1}}};
    phase = sum[MOD_W-1:0];

    r.scan = (divider == SCAN_DIVIDE - 1);
    divider = r.scan ? 0 : divider + 1;
    if (r.scan) begin
      scans++;
      if (tick_owed) begin
        tick_owed = 1'b0;
        advance_ticks(wrap);
        if (wrap) begin
          advance_centivals(wrap);
          if (wrap) advance_intervals();
        end
      end
      cursor = cursor + 2'd1;
      enable_latch  = 4'b0001 << cursor;
      segment_latch = frame[cursor];
      time_button(BTN_CENTIVAL, buttons[0]);
      time_button(BTN_INTERVAL, buttons[1]);
    end
    r.enable    = enable_latch;
    r.segments  = segment_latch;
    r.intervals = intervals;
    r.centivals = centivals;
    r.ticks     = ticks;
    readings_due.push_back(r);
  endtask

  task automatic report(input string what);
    if (errors < MAX_PRINTS) $display("%0t ns: result %0d: %s", $time, checked, what);
    errors++;
  endtask

  task automatic compare_field(input string name, input logic [7:0] got, input logic [7:0] want);
    if (got !== want) report($sformatf("%s is %0h, expected %0h", name, got, want));
  endtask

  task automatic check_reading();
    reading_t want;
    if (readings_due.size() == 0) begin
      report("result arrived with nothing expected");
    end else begin
      want = readings_due.pop_front();
      compare_field("scan_strobe", m_tuser, want.scan);
      compare_field("digit_enable", m_tdata[3:0], want.enable);
      compare_field("segment_drive", m_tdata[11:4], want.segments);
      compare_field("interval_tens", m_tdata[15:12], want.intervals.tens);
      compare_field("interval_units", m_tdata[19:16], want.intervals.units);
      compare_field("centival_tens", m_tdata[23:20], want.centivals.tens);
      compare_field("centival_units", m_tdata[27:24], want.centivals.units);
      compare_field("tick_tens", m_tdata[31:28], want.ticks.tens);
      compare_field("tick_units", m_tdata[35:32], want.ticks.units);
      compare_field("tdata padding", m_tdata[OUT_DATA_W-1:36], 8'd0);
    end
    checked++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      incr          = INC_RESET;
      modulus       = MOD_RESET;
      threshold     = THR_RESET;
      phase         = '0;
      tick_owed     = 1'b0;
      divider       = 0;
      ticks         = '0;
      centivals     = '0;
      intervals     = '0;
      for (int i = 0; i < 4; i++) frame[i] = SEG_ZERO;
      cursor        = 2'd0;
      enable_latch  = 4'd0;
      segment_latch = 8'd0;
      held[0]       = 8'd0;
      held[1]       = 8'd0;
      readings_due.delete();
      errors = 0;
      checked = 0;
      scans = 0;
      advances = 0;
    end else begin
      // a result can never belong to an item taken at the same edge
      if (m_tvalid && m_tready) check_reading();
      if (s_tvalid && s_tready) predict_reading(s_tdata[1:0]);
      if (cfg_we) begin
        case (cfg_index)
          REG_STEP_INCREMENT:  incr      = cfg_data[INC_W-1:0];
          REG_STEP_MODULUS:    modulus   = cfg_data[MOD_W-1:0];
          REG_PRESS_THRESHOLD: threshold = cfg_data[THR_W-1:0];
          default: ;
        endcase
      end
    end
    outstanding = readings_due.size();
  end

endmodule

@@ tb/sv/decimal_time_clock_counter_top_tb.sv @@
// testbench top for the decimal time clock counter: stimulus, back-pressure and verdict
module decimal_time_clock_counter_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dtc_pkg::*;

  // cycles without any handshake before the run is declared hung
  localparam int QUIET_LIMIT   = 2000;
  // settling time after the last result, well above what the two output stages need
  localparam int DRAIN_CYCLES  = 8;
  localparam int RANDOM_ITEMS  = 512;
  localparam int RANDOM_BLOCKS = 8;
  // scan steps in the deep run
  localparam int DEEP_SCANS    = 12;
  // an index past the last register, writes to it must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef enum int {PACE_FULL, PACE_SENDER_IDLE, PACE_RECEIVER_STALL, PACE_BOTH} pace_e;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b1;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tuser;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_W-1:0]      cfg_data = '0;

  int errors, outstanding, checked, scans, advances;

  // pacing and button plan
  int         idle_pct = 0;
  int         stall_pct = 0;
  int         noise_pct = 0;
  int         press_lo = 1;
  int         press_hi = 3;
  int         release_hi = 3;
  int         sent = 0;
  int         quiet = 0;
  logic [1:0] btn_level = 2'b00;
  int         btn_left [2];

  decimal_time_clock_counter_top u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  decimal_time_clock_counter_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .errors      (errors),
    .outstanding (outstanding),
    .checked     (checked),
    .scans       (scans),
    .advances    (advances)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver back-pressure, redrawn every cycle
  always @(negedge clk) begin
    m_tready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
  end

  // watchdog: any accepted item on either side restarts the count
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("decimal_time_clock_counter_top regression: fail");
        $finish;
      end
    end
  end

  task automatic set_pace(input pace_e p);
    case (p)
      PACE_FULL: begin
        idle_pct = 0;
        stall_pct = 0;
      end
      PACE_SENDER_IDLE: begin
        idle_pct = 71;
        stall_pct = 0;
      end
      PACE_RECEIVER_STALL: begin
        idle_pct = 0;
        stall_pct = 71;
      end
      default: begin
        idle_pct = 35;
        stall_pct = 35;
      end
    endcase
  endtask

  // start both buttons released with a fresh plan, so the next scan begins a press
  task automatic restart_plan();
    btn_level = 2'b00;
    btn_left[0] = 0;
    btn_left[1] = 0;
  endtask

  // levels between scan steps are pure noise; on a scan step the plan decides,
  // apart from an occasional broken press
  task automatic next_buttons(output logic [1:0] b);
    if ((sent % SCAN_DIVIDE) != SCAN_DIVIDE - 1) begin
      b = 2'($urandom_range(3));
    end else begin
      for (int i = 0; i < 2; i++) begin
        if (btn_left[i] == 0) begin
          btn_level[i] = ~btn_level[i];
          btn_left[i]  = btn_level[i] ? $urandom_range(press_hi, press_lo)
                                      : $urandom_range(release_hi, 1);
        end
        btn_left[i]--;
      end
      b = btn_level;
      if (noise_pct != 0 && $urandom_range(99) < noise_pct) b = 2'($urandom_range(3));
    end
  endtask

  // offers one item after a random gap and returns at the falling edge after it is taken
  task automatic send_item(input logic [1:0] buttons);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      s_tdata  <= IN_DATA_W'($urandom_range(255));
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(IN_DATA_W-2){1'b0}}, buttons};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent++;
    @(negedge clk);
  endtask

  task automatic run_items(input int n);
    logic [1:0] b;
    repeat (n) begin
      next_buttons(b);
      send_item(b);
    end
  endtask

  // stop offering and wait until every expected result is back, plus margin
  task automatic settle();
    s_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // write enable stays high across consecutive writes and drops once at the end
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
  endtask

  task automatic configure(input logic [CFG_W-1:0] inc, input logic [CFG_W-1:0] modv,
                           input logic [CFG_W-1:0] thr, input bit poke_unused);
    settle();
    if (poke_unused) write_reg(REG_UNUSED, {CFG_W{1'b1}});
    write_reg(REG_STEP_INCREMENT, inc);
    write_reg(REG_STEP_MODULUS, modv);
    write_reg(REG_PRESS_THRESHOLD, thr);
    cfg_we <= 1'b0;
  endtask

  // random setting biased towards frequent ticks and short press thresholds
  task automatic random_config();
    logic [CFG_W-1:0] inc, modv, thr;
    inc  = CFG_W'($urandom_range(65535, 1));
    modv = ($urandom_range(1) == 0) ? CFG_W'($urandom_range(inc, 1))
                                    : CFG_W'($urandom_range(131071, 1));
    thr  = ($urandom_range(3) == 0) ? CFG_W'($urandom_range(254)) : CFG_W'($urandom_range(3));
    configure(inc, modv, thr, 1'b0);
    press_lo   = (thr == 0) ? 1 : int'(thr);
    press_hi   = press_lo + 3;
    release_hi = 3;
    noise_pct  = 12;
  endtask

  initial begin
    btn_left[0] = 0;
    btn_left[1] = 0;
    set_pace(PACE_FULL);
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // reset register values, every button combination, first scan at item 16
    for (int k = 0; k < 24; k++) send_item(2'(k));

    // zero modulus: a tick on every item and the sum saturates; the increment
    // write carries a stray bit 16 and the unused index is hit
    configure({CFG_W{1'b1}}, '0, '0, 1'b1);
    run_items(40);

    // unit modulus on a saturated accumulator: overflow after the subtraction
    configure(CFG_W'(65535), CFG_W'(1), '0, 1'b0);
    run_items(40);

    // slowest setting: a single tick off the saturated accumulator, then no tick at all
    configure(CFG_W'(1), CFG_W'(131071), CFG_W'(254), 1'b0);
    run_items(48);

    // random content under every pacing mode
    for (int p = 0; p < 4; p++) begin
      set_pace(pace_e'(p));
      for (int k = 0; k < RANDOM_BLOCKS / 4; k++) begin
        random_config();
        run_items(RANDOM_ITEMS / RANDOM_BLOCKS);
      end
    end

    // deep run: a tick on every scan and a button advance every few scans, so
    // the decimal point toggles and both buttons move their counters
    set_pace(PACE_FULL);
    noise_pct = 0;
    press_lo = 1;
    press_hi = 1;
    release_hi = 2;
    configure(CFG_W'(1), CFG_W'(1), '0, 1'b0);
    restart_plan();
    run_items(DEEP_SCANS * SCAN_DIVIDE);

    set_pace(PACE_BOTH);
    random_config();
    run_items(64);

    settle();
    $display("run covered %0d items and %0d results: %0d scan steps, %0d button advances",
             sent, checked, scans, advances);
    $display("settings went from reset values through zero and unit modulus to thresholds 0-254");
    if (errors == 0 && outstanding == 0) begin
      $display("decimal_time_clock_counter_top regression: pass");
    end else begin
      $display("decimal_time_clock_counter_top regression: fail");
    end
    $finish;
  end

endmodule
